// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: hdl/fes_pkg.sv
// Types, constants and helper functions of the frame element stiffness block.
`default_nettype none
package fes_pkg;
    localparam int OUT_FRAC_BITS = 24;
    localparam int NUM_W = OUT_FRAC_BITS + 116;
    localparam int DEN_W = 128;
    localparam int DIV_W = DEN_W + 66;
    localparam int NSLOT = 9;
    localparam int SLOT_W = 4;
    localparam int ROW_W = 3;
    localparam logic [ROW_W-1:0] ROW_LAST = 3'd5;
    localparam int IN_W = 104;
    localparam int OUT_W = 448;

    localparam logic [1:0] CFG_YOUNG = 2'd0;
    localparam logic [1:0] CFG_AREA = 2'd1;
    localparam logic [1:0] CFG_INERTIA = 2'd2;

    localparam logic [SLOT_W-1:0] SLOT_EA = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_S1 = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_S2 = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_S3 = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_S4 = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_LA = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_P0 = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_P1 = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_P2 = 4'd8;

    typedef enum logic [2:0] {
        REL_RIGID  = 3'd0,
        REL_HINGE  = 3'd1,
        REL_SLEEVE = 3'd2,
        REL_SLIDER = 3'd3,
        REL_ROLLER = 3'd4
    } t_rel;

    typedef enum logic [2:0] {
        BEND_NONE   = 3'd0,
        BEND_SPRING = 3'd1,
        BEND_FULL   = 3'd2,
        BEND_PIN_S  = 3'd3,
        BEND_PIN_E  = 3'd4
    } t_bend;

    typedef enum logic [1:0] {
        LD_FIXED    = 2'd0,
        LD_PIN_S    = 2'd1,
        LD_PIN_E    = 2'd2,
        LD_PIN_BOTH = 2'd3
    } t_ldc;

    typedef struct packed {
        logic [31:0] len;
        logic [31:0] qp;
        logic [31:0] qa;
        t_bend       bend;
        t_ldc        ldc;
        logic        ax;
    } t_job;

    typedef struct packed {
        logic       en;
        logic       is_load;
        logic       alt;
        logic [3:0] c;
        logic [1:0] k;
        logic [3:0] cd;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Division job of one result slot for a given release pattern.
    function automatic t_op slot_op(input logic [SLOT_W-1:0] slot, input t_bend bend,
                                    input t_ldc ldc, input logic ax);
        t_op op;
        op = '0;
        op.cd = 4'd1;
        case (slot)
            SLOT_EA: begin
                op.en = ax; op.alt = 1'b1; op.c = 4'd1; op.k = 2'd1;
            end
            SLOT_S1: begin
                case (bend)
                    BEND_SPRING: begin op.en = 1'b1; op.c = 4'd1; op.k = 2'd1; end
                    BEND_FULL: begin op.en = 1'b1; op.c = 4'd12; op.k = 2'd3; end
                    BEND_PIN_S, BEND_PIN_E: begin op.en = 1'b1; op.c = 4'd3; op.k = 2'd3; end
                    default: op.en = 1'b0;
                endcase
            end
            SLOT_S2: begin
                case (bend)
                    BEND_FULL: begin op.en = 1'b1; op.c = 4'd6; op.k = 2'd2; end
                    BEND_PIN_S, BEND_PIN_E: begin op.en = 1'b1; op.c = 4'd3; op.k = 2'd2; end
                    default: op.en = 1'b0;
                endcase
            end
            SLOT_S3: begin
                case (bend)
                    BEND_FULL: begin op.en = 1'b1; op.c = 4'd4; op.k = 2'd1; end
                    BEND_PIN_S, BEND_PIN_E: begin op.en = 1'b1; op.c = 4'd3; op.k = 2'd1; end
                    default: op.en = 1'b0;
                endcase
            end
            SLOT_S4: begin
                op.en = (bend == BEND_FULL); op.c = 4'd2; op.k = 2'd1;
            end
            SLOT_LA: begin
                op.en = ax; op.is_load = 1'b1; op.alt = 1'b1;
                op.c = 4'd1; op.cd = 4'd2; op.k = 2'd1;
            end
            SLOT_P0: begin
                op.en = 1'b1; op.is_load = 1'b1; op.k = 2'd1;
                case (ldc)
                    LD_PIN_S: begin op.c = 4'd3; op.cd = 4'd8; end
                    LD_PIN_E: begin op.c = 4'd5; op.cd = 4'd8; end
                    default: begin op.c = 4'd1; op.cd = 4'd2; end
                endcase
            end
            SLOT_P1: begin
                op.is_load = 1'b1;
                case (ldc)
                    LD_FIXED: begin op.en = 1'b1; op.c = 4'd1; op.cd = 4'd12; op.k = 2'd2; end
                    LD_PIN_S: begin op.en = 1'b1; op.c = 4'd5; op.cd = 4'd8; op.k = 2'd1; end
                    LD_PIN_E: begin op.en = 1'b1; op.c = 4'd1; op.cd = 4'd8; op.k = 2'd2; end
                    default: op.en = 1'b0;
                endcase
            end
            SLOT_P2: begin
                op.is_load = 1'b1;
                case (ldc)
                    LD_PIN_S: begin op.en = 1'b1; op.c = 4'd1; op.cd = 4'd8; op.k = 2'd2; end
                    LD_PIN_E: begin op.en = 1'b1; op.c = 4'd3; op.cd = 4'd8; op.k = 2'd1; end
                    default: op.en = 1'b0;
                endcase
            end
            default: op.en = 1'b0;
        endcase
        return op;
    endfunction

    // Magnitude to signed output with saturation.
    function automatic logic [63:0] to_q(input logic [63:0] m, input logic neg);
        logic [63:0] r;
        if (!neg) begin
            r = m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
        end else begin
            r = m[63] ? 64'h8000_0000_0000_0000 : (~m + 64'd1);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hdl/frame_element_stiffness_unit.sv
// Top level of the frame element stiffness block.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: beam (length, loads, releases)
//  m_axis    out  m_axis_tvalid/tready       tdata: row entries, tuser: row, tlast
//  cfg       in   i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// Each beam needs D divisions, D = enabled divisions (1 to 8, 8 for a rigid beam),
// run in turn on the shared bit-serial divider, one quotient bit a cycle; a division
// with a zero numerator is done without the quotient iteration.
// A two-deep job queue keeps taking beams while the back end works.
// The output register lets the back end start the next beam while the last
// row of the previous one waits. Reset is synchronous, active low; no clearing.
`default_nettype none
`include "assert_macros.svh"
module frame_element_stiffness_unit import fes_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [31:0] length, [63:32] perp_load, [95:64] axial_load,
    // [98:96] start_release, [101:99] end_release, [103:102] zero
    input  wire logic [IN_W-1:0]     s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [63:0] k_col0 ... [383:320] k_col5, [447:384] equiv_load
    output logic [OUT_W-1:0]         m_axis_tdata,
    // [2:0] row_index
    output logic [ROW_W-1:0]         m_axis_tuser,
    output logic                     m_axis_tlast,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data
);
    logic [31:0] r_young, r_area, r_inertia;
    t_qstat w_qstat;
    t_job w_job, w_head;
    logic w_push, w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_young <= 32'd210000000;
            r_area <= 32'd21474836;
            r_inertia <= 32'd214748;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_YOUNG: r_young <= i_cfg_data;
                CFG_AREA: r_area <= i_cfg_data;
                CFG_INERTIA: r_inertia <= i_cfg_data;
                default: r_young <= r_young;
            endcase
        end
    end

    fes_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_job         (w_job)
    );

    fes_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    fes_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .i_young       (r_young),
        .i_area        (r_area),
        .i_inertia     (r_inertia),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `ASSERT_ALWAYS(a_q_state, i_clk, i_rst_n, !(w_qstat.full && w_qstat.empty), "queue full and empty")
    `ASSERT_IMPLY(a_last_row, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == ROW_LAST), "tlast off row five")
    `ASSERT_IMPLY(a_row_rng, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= ROW_LAST, "row index out of range")
    `ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, w_qstat.full, !w_push || w_pop, "push into full queue")
endmodule
`default_nettype wire

// File: hdl/fes_front.sv
// Front end: takes beams and classifies their release pattern.
`default_nettype none
module fes_front import fes_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [IN_W-1:0] s_axis_tdata,
    input  wire t_qstat          i_qstat,
    output logic                 o_push,
    output t_job                 o_job
);
    logic [2:0] w_s;
    logic [2:0] w_e;
    logic w_ms, w_me, w_ns, w_ne, w_ts, w_te;
    logic r_seen;

    assign w_s = s_axis_tdata[98:96];
    assign w_e = s_axis_tdata[101:99];
    assign w_ms = (w_s == REL_HINGE) || (w_s == REL_ROLLER);
    assign w_me = (w_e == REL_HINGE) || (w_e == REL_ROLLER);
    assign w_ns = (w_s == REL_SLEEVE) || (w_s == REL_ROLLER);
    assign w_ne = (w_e == REL_SLEEVE) || (w_e == REL_ROLLER);
    assign w_ts = (w_s == REL_SLIDER);
    assign w_te = (w_e == REL_SLIDER);

    // ready only once out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seen <= 1'b0;
        else r_seen <= 1'b1;
    end

    assign s_axis_tready = r_seen && !i_qstat.full;
    assign o_push = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_job.len = s_axis_tdata[31:0];
        o_job.qp = s_axis_tdata[63:32];
        o_job.qa = s_axis_tdata[95:64];
        o_job.ax = !w_ns && !w_ne;
        if (w_ts || w_te) o_job.bend = BEND_SPRING;
        else if (!w_ms && !w_me) o_job.bend = BEND_FULL;
        else if (w_ms && !w_me) o_job.bend = BEND_PIN_S;
        else if (!w_ms && w_me) o_job.bend = BEND_PIN_E;
        else o_job.bend = BEND_NONE;
        if (!w_ms && !w_me) o_job.ldc = LD_FIXED;
        else if (w_ms && !w_me) o_job.ldc = LD_PIN_S;
        else if (!w_ms && w_me) o_job.ldc = LD_PIN_E;
        else o_job.ldc = LD_PIN_BOTH;
    end
endmodule
`default_nettype wire

// File: hdl/fes_fifo.sv
// Two-entry job queue between front and back.
`default_nettype none
module fes_fifo import fes_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output t_qstat    o_stat
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_head = r_mem[r_rp];
    assign o_stat.full = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule
`default_nettype wire

// File: hdl/fes_div.sv
// Restoring divider: round(num/den), half up, saturating to 64 bits.
`default_nettype none
module fes_div import fes_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [63:0]           o_quot
);
    logic [DIV_W-1:0] r_rem, r_dsh;
    logic [63:0] r_q;
    logic [6:0] r_step;
    logic r_act, r_ovf, r_done;
    logic w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_done <= (i_num == '0);
                r_act <= (i_num != '0);
            end else if (r_act && r_step == 7'd64) begin
                r_act <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // 2*num+den over 2*den gives the rounded quotient; step 0 tests overflow
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DIV_W'(i_num) << 1) + DIV_W'(i_den);
            r_dsh <= DIV_W'(i_den) << 65;
            r_q <= '0;
            r_ovf <= 1'b0;
            r_step <= '0;
        end else if (r_act) begin
            if (w_ge) r_rem <= r_rem - r_dsh;
            if (r_step == 7'd0) r_ovf <= w_ge;
            else r_q <= {r_q[62:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_step <= r_step + 7'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_ovf ? '1 : r_q;
endmodule
`default_nettype wire

// File: hdl/fes_back.sv
// Back end: products, shared divider, row assembly and output register.
`default_nettype none
module fes_back import fes_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_job              i_head,
    input  wire t_qstat            i_qstat,
    output logic                   o_pop,
    input  wire logic [31:0]       i_young,
    input  wire logic [31:0]       i_area,
    input  wire logic [31:0]       i_inertia,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,
    output logic [ROW_W-1:0]       m_axis_tuser,
    output logic                   m_axis_tlast
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_bstate;

    localparam logic [3:0] MS_L2    = 4'd0;
    localparam logic [3:0] MS_EI    = 4'd1;
    localparam logic [3:0] MS_EA    = 4'd2;
    localparam logic [3:0] MS_QAL   = 4'd3;
    localparam logic [3:0] MS_QPL   = 4'd4;
    localparam logic [3:0] MS_L3LO  = 4'd5;
    localparam logic [3:0] MS_L3HI  = 4'd6;
    localparam logic [3:0] MS_QL2LO = 4'd7;
    localparam logic [3:0] MS_QL2HI = 4'd8;
    localparam logic [3:0] MS_END   = 4'd9;

    t_bstate r_st;
    t_job r_job;
    logic [3:0] r_mcnt, r_pstep;
    logic r_pv;
    logic [63:0] r_prod;
    logic [63:0] r_l2, r_ei, r_ea, r_qal, r_qpl;
    logic [95:0] r_l3, r_qpl2;
    logic [SLOT_W-1:0] r_slot;
    logic r_busy;
    logic [63:0] r_res [NSLOT];
    logic [ROW_W-1:0] r_row;
    logic r_ovalid, r_olast;
    logic [OUT_W-1:0] r_odata;
    logic [ROW_W-1:0] r_orow;

    logic qa_neg, qp_neg;
    logic [31:0] qa_mag, qp_mag, w_ma, w_mb;
    t_op w_op;
    logic [67:0] w_sprod;
    logic [98:0] w_lprod;
    logic [95:0] w_lbase, w_lk;
    logic [NUM_W-1:0] w_num;
    logic [DEN_W-1:0] w_den;
    logic w_start, w_done, w_emit;
    logic [63:0] w_quot;
    logic [63:0] km [6][6];
    logic [63:0] fv [6];

    assign qa_neg = r_job.qa[31];
    assign qp_neg = r_job.qp[31];
    assign qa_mag = qa_neg ? (32'd0 - r_job.qa) : r_job.qa;
    assign qp_mag = qp_neg ? (32'd0 - r_job.qp) : r_job.qp;

    // multiply operand schedule
    always_comb begin
        case (r_mcnt)
            MS_L2:    begin w_ma = r_job.len;  w_mb = r_job.len; end
            MS_EI:    begin w_ma = i_young;    w_mb = i_inertia; end
            MS_EA:    begin w_ma = i_young;    w_mb = i_area; end
            MS_QAL:   begin w_ma = qa_mag;     w_mb = r_job.len; end
            MS_QPL:   begin w_ma = qp_mag;     w_mb = r_job.len; end
            MS_L3LO:  begin w_ma = r_l2[31:0]; w_mb = r_job.len; end
            MS_L3HI:  begin w_ma = r_l2[63:32]; w_mb = r_job.len; end
            MS_QL2LO: begin w_ma = r_l2[31:0]; w_mb = qp_mag; end
            MS_QL2HI: begin w_ma = r_l2[63:32]; w_mb = qp_mag; end
            default:  begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // operands of the current division slot
    always_comb begin
        w_op = slot_op(r_slot, r_job.bend, r_job.ldc, r_job.ax);
        case (w_op.k)
            2'd2: w_lk = {32'd0, r_l2};
            2'd3: w_lk = r_l3;
            default: w_lk = {64'd0, r_job.len};
        endcase
        w_lbase = w_op.alt ? {32'd0, r_qal} : ((w_op.k == 2'd1) ? {32'd0, r_qpl} : r_qpl2);
        w_sprod = (w_op.alt ? r_ea : r_ei) * w_op.c;
        w_lprod = w_lbase * w_op.c;
        if (w_op.is_load) begin
            w_num = NUM_W'(w_lprod) << OUT_FRAC_BITS;
            w_den = DEN_W'(w_op.cd) << (7'd16 * ({5'd0, w_op.k} + 7'd1));
        end else begin
            w_num = NUM_W'(w_sprod) << (OUT_FRAC_BITS + 16 * int'(w_op.k));
            w_den = DEN_W'(w_lk) << 32;
        end
    end

    assign w_start = (r_st == ST_DIV) && w_op.en && !r_busy;

    fes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    assign o_pop = (r_st == ST_IDLE) && !i_qstat.empty;
    assign w_emit = (r_st == ST_EMIT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_mcnt <= '0;
            r_pv <= 1'b0;
            r_slot <= '0;
            r_busy <= 1'b0;
            r_row <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pv <= (r_st == ST_MUL) && (r_mcnt != MS_END);
            if (w_emit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_st <= ST_MUL;
                        r_mcnt <= '0;
                    end
                end
                ST_MUL: begin
                    if (r_mcnt == MS_END) begin
                        r_st <= ST_DIV;
                        r_slot <= '0;
                        r_busy <= 1'b0;
                    end else begin
                        r_mcnt <= r_mcnt + 4'd1;
                    end
                end
                ST_DIV: begin
                    if (w_start) begin
                        r_busy <= 1'b1;
                    end else if (!w_op.en || w_done) begin
                        r_busy <= 1'b0;
                        if (r_slot == SLOT_W'(NSLOT - 1)) begin
                            r_st <= ST_EMIT;
                            r_row <= '0;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        if (r_row == ROW_LAST) r_st <= ST_IDLE;
                        else r_row <= r_row + 1'b1;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // payload: job latch, product pipeline, division results, output row
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_head;
        r_prod <= w_ma * w_mb;
        r_pstep <= r_mcnt;
        if (r_pv) begin
            case (r_pstep)
                MS_L2:    r_l2 <= r_prod;
                MS_EI:    r_ei <= r_prod;
                MS_EA:    r_ea <= r_prod;
                MS_QAL:   r_qal <= r_prod;
                MS_QPL:   r_qpl <= r_prod;
                MS_L3LO:  r_l3 <= {32'd0, r_prod};
                MS_L3HI:  r_l3 <= r_l3 + {r_prod, 32'd0};
                MS_QL2LO: r_qpl2 <= {32'd0, r_prod};
                MS_QL2HI: r_qpl2 <= r_qpl2 + {r_prod, 32'd0};
                default:  r_l2 <= r_l2;
            endcase
        end
        if ((r_st == ST_DIV) && w_done) r_res[r_slot] <= w_quot;
        if (w_emit) begin
            r_odata <= {fv[r_row], km[r_row][5], km[r_row][4], km[r_row][3],
                        km[r_row][2], km[r_row][1], km[r_row][0]};
            r_orow <= r_row;
            r_olast <= (r_row == ROW_LAST);
        end
    end

    // local matrix and load vector from the slot results
    always_comb begin
        logic [3:0] rot;
        logic nqp;
        nqp = !qp_neg;
        for (int r = 0; r < 6; r++) begin
            fv[r] = '0;
            for (int c = 0; c < 6; c++) km[r][c] = '0;
        end
        rot = (r_job.bend == BEND_PIN_S) ? 4'd5 : 4'd2;
        if (r_job.ax) begin
            km[0][0] = to_q(r_res[SLOT_EA], 1'b0);
            km[3][3] = km[0][0];
            km[0][3] = to_q(r_res[SLOT_EA], 1'b1);
            km[3][0] = km[0][3];
            fv[0] = to_q(r_res[SLOT_LA], !qa_neg);
            fv[3] = fv[0];
        end
        case (r_job.bend)
            BEND_SPRING: begin
                km[2][2] = to_q(r_res[SLOT_S1], 1'b0);
                km[5][5] = km[2][2];
                km[2][5] = to_q(r_res[SLOT_S1], 1'b1);
                km[5][2] = km[2][5];
            end
            BEND_FULL: begin
                km[1][1] = to_q(r_res[SLOT_S1], 1'b0);
                km[4][4] = km[1][1];
                km[1][4] = to_q(r_res[SLOT_S1], 1'b1);
                km[4][1] = km[1][4];
                km[1][2] = to_q(r_res[SLOT_S2], 1'b0);
                km[1][5] = km[1][2];
                km[2][1] = km[1][2];
                km[5][1] = km[1][2];
                km[2][4] = to_q(r_res[SLOT_S2], 1'b1);
                km[4][2] = km[2][4];
                km[4][5] = km[2][4];
                km[5][4] = km[2][4];
                km[2][2] = to_q(r_res[SLOT_S3], 1'b0);
                km[5][5] = km[2][2];
                km[2][5] = to_q(r_res[SLOT_S4], 1'b0);
                km[5][2] = km[2][5];
            end
            BEND_PIN_S, BEND_PIN_E: begin
                km[1][1] = to_q(r_res[SLOT_S1], 1'b0);
                km[4][4] = km[1][1];
                km[1][4] = to_q(r_res[SLOT_S1], 1'b1);
                km[4][1] = km[1][4];
                km[1][rot[2:0]] = to_q(r_res[SLOT_S2], 1'b0);
                km[rot[2:0]][1] = to_q(r_res[SLOT_S2], 1'b0);
                km[4][rot[2:0]] = to_q(r_res[SLOT_S2], 1'b1);
                km[rot[2:0]][4] = to_q(r_res[SLOT_S2], 1'b1);
                km[rot[2:0]][rot[2:0]] = to_q(r_res[SLOT_S3], 1'b0);
            end
            default: km[0][1] = '0;
        endcase
        case (r_job.ldc)
            LD_FIXED: begin
                fv[1] = to_q(r_res[SLOT_P0], nqp);
                fv[4] = fv[1];
                fv[2] = to_q(r_res[SLOT_P1], nqp);
                fv[5] = to_q(r_res[SLOT_P1], qp_neg);
            end
            LD_PIN_S: begin
                fv[1] = to_q(r_res[SLOT_P0], nqp);
                fv[4] = to_q(r_res[SLOT_P1], nqp);
                fv[5] = to_q(r_res[SLOT_P2], qp_neg);
            end
            LD_PIN_E: begin
                fv[1] = to_q(r_res[SLOT_P0], nqp);
                fv[2] = to_q(r_res[SLOT_P1], nqp);
                fv[4] = to_q(r_res[SLOT_P2], nqp);
            end
            default: begin
                fv[1] = to_q(r_res[SLOT_P0], nqp);
                fv[4] = fv[1];
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_orow;
    assign m_axis_tlast = r_olast;
endmodule
`default_nettype wire

// File: tb/sv/frame_element_stiffness_unit_tb.sv
// Self-checking testbench of the frame element stiffness unit.
`default_nettype none
module frame_element_stiffness_unit_tb;
    import fes_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 700;   // sized to cover a rigid beam

    typedef struct {
        bit [2:0]   row;
        bit [63:0]  col [7];   // k_col0..k_col5, then equiv_load
        bit         last;
    } t_row_exp;

    // Scoreboard: own copy of the registers, predicts the six rows of a beam.
    class stiffness_board;
        bit [31:0] young, area, inertia;
        t_row_exp  rows_due[$];
        int        errors;
        int        rows_seen;
        int        beams_seen;

        function new();
            young = 32'd210000000;
            area = 32'd21474836;
            inertia = 32'd214748;
        endfunction

        function void set_reg(logic [1:0] idx, bit [31:0] val);
            if (idx == CFG_YOUNG) young = val;
            else if (idx == CFG_AREA) area = val;
            else if (idx == CFG_INERTIA) inertia = val;
        endfunction

        // round(n/d), halves up, saturating to all ones
        function bit [63:0] div_round(bit [255:0] n, bit [255:0] d);
            bit [255:0] q;
            if (d == 0) return (n == 0) ? 64'd0 : '1;
            q = (2 * n + d) / (2 * d);
            if (q[255:64] != 0) return '1;
            return q[63:0];
        endfunction

        function bit [63:0] ratio(bit [31:0] a, bit [31:0] b, bit [31:0] cn, int pn, int sn,
                                  bit [31:0] cd, int pd, int sd, bit [31:0] len);
            bit [255:0] n, d;
            n = a;
            n = n * b;
            n = n * cn;
            repeat (pn) n = n * len;
            n = n << sn;
            d = cd;
            repeat (pd) d = d * len;
            d = d << sd;
            return div_round(n, d);
        endfunction

        function bit [63:0] signed_q(bit [63:0] m, bit neg);
            if (!neg) return m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
            if (m[63]) return 64'h8000_0000_0000_0000;
            return ~m + 64'd1;
        endfunction

        // c * E * I / L^k
        function bit [63:0] bend_term(bit [31:0] c, int k, bit [31:0] len);
            return ratio(young, inertia, c, 0, OUT_FRAC_BITS + 16 * k, 1, k, 32, len);
        endfunction

        // (cn/cd) * q * L^k, coefficient sign flipped when neg_coef
        function bit [63:0] load_term(bit [31:0] q, bit [31:0] cn, bit [31:0] cd, int k,
                                      bit neg_coef, bit [31:0] len);
            bit [31:0] qmag;
            bit [63:0] m;
            qmag = q[31] ? -q : q;
            m = ratio(qmag, 1, cn, k, OUT_FRAC_BITS, cd, 0, 16 * (k + 1), len);
            return signed_q(m, q[31] != neg_coef);
        endfunction

        function void note_beam(bit [31:0] len, bit [31:0] qp, bit [31:0] qa,
                                logic [2:0] s, logic [2:0] e);
            bit [63:0] km [6][6];
            bit [63:0] fl [6];
            bit [63:0] ea, a, b, c4, c2, cc;
            bit mom_s, mom_e, ax_s, ax_e, sl_s, sl_e;
            int rot;
            t_row_exp x;
            mom_s = (s == REL_HINGE) || (s == REL_ROLLER);
            mom_e = (e == REL_HINGE) || (e == REL_ROLLER);
            ax_s = (s == REL_SLEEVE) || (s == REL_ROLLER);
            ax_e = (e == REL_SLEEVE) || (e == REL_ROLLER);
            sl_s = (s == REL_SLIDER);
            sl_e = (e == REL_SLIDER);
            foreach (km[r, c]) km[r][c] = 64'd0;
            foreach (fl[r]) fl[r] = 64'd0;
            beams_seen++;

            if (!ax_s && !ax_e) begin
                ea = ratio(young, area, 1, 0, OUT_FRAC_BITS + 16, 1, 1, 32, len);
                km[0][0] = signed_q(ea, 0); km[3][3] = km[0][0];
                km[0][3] = signed_q(ea, 1); km[3][0] = km[0][3];
                fl[0] = load_term(qa, 1, 2, 1, 1, len); fl[3] = fl[0];
            end
            if (sl_s || sl_e) begin
                // slider: bending reduced to a rotational spring E*I/L
                a = bend_term(1, 1, len);
                km[2][2] = signed_q(a, 0); km[5][5] = km[2][2];
                km[2][5] = signed_q(a, 1); km[5][2] = km[2][5];
            end else if (!mom_s && !mom_e) begin
                a = bend_term(12, 3, len); b = bend_term(6, 2, len);
                c4 = bend_term(4, 1, len); c2 = bend_term(2, 1, len);
                km[1][1] = signed_q(a, 0); km[4][4] = km[1][1];
                km[1][4] = signed_q(a, 1); km[4][1] = km[1][4];
                km[1][2] = signed_q(b, 0); km[1][5] = km[1][2];
                km[2][1] = km[1][2]; km[5][1] = km[1][2];
                km[2][4] = signed_q(b, 1); km[4][2] = km[2][4];
                km[4][5] = km[2][4]; km[5][4] = km[2][4];
                km[2][2] = signed_q(c4, 0); km[5][5] = km[2][2];
                km[2][5] = signed_q(c2, 0); km[5][2] = km[2][5];
            end else if (mom_s != mom_e) begin
                // one pinned end: propped cantilever terms on the other rotation
                a = bend_term(3, 3, len); b = bend_term(3, 2, len); cc = bend_term(3, 1, len);
                rot = mom_s ? 5 : 2;
                km[1][1] = signed_q(a, 0); km[4][4] = km[1][1];
                km[1][4] = signed_q(a, 1); km[4][1] = km[1][4];
                km[1][rot] = signed_q(b, 0); km[rot][1] = km[1][rot];
                km[4][rot] = signed_q(b, 1); km[rot][4] = km[4][rot];
                km[rot][rot] = signed_q(cc, 0);
            end

            if (!mom_s && !mom_e) begin
                fl[1] = load_term(qp, 1, 2, 1, 1, len); fl[4] = fl[1];
                fl[2] = load_term(qp, 1, 12, 2, 1, len);
                fl[5] = load_term(qp, 1, 12, 2, 0, len);
            end else if (mom_s && !mom_e) begin
                fl[1] = load_term(qp, 3, 8, 1, 1, len);
                fl[4] = load_term(qp, 5, 8, 1, 1, len);
                fl[5] = load_term(qp, 1, 8, 2, 0, len);
            end else if (!mom_s && mom_e) begin
                fl[1] = load_term(qp, 5, 8, 1, 1, len);
                fl[2] = load_term(qp, 1, 8, 2, 1, len);
                fl[4] = load_term(qp, 3, 8, 1, 1, len);
            end else begin
                fl[1] = load_term(qp, 1, 2, 1, 1, len); fl[4] = fl[1];
            end

            for (int r = 0; r < 6; r++) begin
                x.row = r[2:0];
                for (int c = 0; c < 6; c++) x.col[c] = km[r][c];
                x.col[6] = fl[r];
                x.last = (r == 5);
                rows_due.push_back(x);
            end
        endfunction

        function void check_row(bit [OUT_W-1:0] data, bit [ROW_W-1:0] row, bit last);
            t_row_exp x;
            rows_seen++;
            if (rows_due.size() == 0) begin
                $display("%0t: row %0d arrived with none expected", $time, row);
                errors++;
                return;
            end
            x = rows_due.pop_front();
            if (row != x.row) begin
                $display("%0t: row_index expected %0d actual %0d", $time, x.row, row);
                errors++;
            end
            if (last != x.last) begin
                $display("%0t: last_row expected %0d actual %0d", $time, x.last, last);
                errors++;
            end
            for (int c = 0; c < 7; c++)
                if (data[c*64 +: 64] != x.col[c]) begin
                    $display("%0t: row %0d field %0d expected %h actual %h",
                             $time, x.row, c, x.col[c], data[c*64 +: 64]);
                    errors++;
                end
        endfunction

        function int pending();
            return rows_due.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;    // length, perp_load, axial_load, start rel, end rel
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;    // k_col0..k_col5, equiv_load
    logic [ROW_W-1:0]   m_axis_tuser;    // row_index
    logic               m_axis_tlast;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;

    stiffness_board board;
    bit  quiet;          // no idling on either side in the closing phase
    int  cycles;
    int  sink_hold;

    frame_element_stiffness_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle budget: the run fails once the cycle count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("frame_element_stiffness_unit verification failed");
            $finish;
        end
    end

    // Result monitor: sample the handshake at the rising edge.
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_row(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    // Sink backpressure: random stall bursts, off when quiet.
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_axis_tready = 1'b0;
        end else if (!quiet && $urandom_range(7, 0) == 0) begin
            sink_hold = $urandom_range(5, 0);
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Register write; only called while the block is idle. Enters/leaves at negedge.
    task automatic write_reg(logic [1:0] idx, bit [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        board.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(bit [31:0] e, bit [31:0] a, bit [31:0] i);
        write_reg(CFG_YOUNG, e);
        write_reg(CFG_AREA, a);
        write_reg(CFG_INERTIA, i);
    endtask

    // Offer one beam; returns at the falling edge after it is taken.
    task automatic send_beam(bit [31:0] len, bit [31:0] qp, bit [31:0] qa,
                             logic [2:0] s, logic [2:0] e);
        if (!quiet && $urandom_range(5, 0) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, e, s, qa, qp, len};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_beam(len, qp, qa, s, e);
        @(negedge i_clk);
    endtask

    // Let everything drain, then wait DRAIN_CYCLES more before a register write.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic bit [31:0] pick_len();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return $urandom_range(655, 1);
            2: return $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
            default: return $urandom_range(32'h0064_0000, 32'h0000_8000); // 0.5 .. 100
        endcase
    endfunction

    function automatic bit [31:0] pick_load();
        case ($urandom_range(5, 0))
            0: return 32'd0;
            1: return $urandom();
            2: return {{16{1'b1}}, 16'(0)} ^ $urandom_range(32'hFFFF, 0);
            default: return $urandom_range(32'h00FF_FFFF, 0) ^ ($urandom_range(1, 0) ? '1 : '0);
        endcase
    endfunction

    function automatic logic [2:0] pick_rel();
        // codes 5..7 are undefined and act as rigid; keep them rare
        return ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4, 0));
    endfunction

    task automatic random_beams(int count);
        for (int n = 0; n < count; n++)
            send_beam(pick_len(), pick_load(), pick_load(), pick_rel(), pick_rel());
    endtask

    initial begin
        board = new();
        quiet = 1'b0;
        cycles = 0;
        sink_hold = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_YOUNG;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: reset registers, every release kind at each end, field extremes.
        send_beam(32'h0005_0000, 32'hFFF6_0000, 32'h0002_0000, REL_RIGID, REL_RIGID);
        for (int r = REL_HINGE; r <= REL_ROLLER; r++) begin
            send_beam(32'h0003_0000, 32'hFFFB_0000, 32'h0001_8000, 3'(r), REL_RIGID);
            send_beam(32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000, REL_RIGID, 3'(r));
        end
        send_beam(32'h0004_0000, 32'h0001_0000, 32'h0001_0000, REL_HINGE, REL_HINGE);
        send_beam(32'h0004_0000, 32'hFFFF_0000, 32'h0001_0000, REL_ROLLER, REL_ROLLER);
        send_beam(32'h0004_0000, 32'h0002_0000, 32'h0003_0000, REL_SLIDER, REL_HINGE);
        send_beam(32'h0004_0000, 32'h0002_0000, 32'h0003_0000, REL_SLEEVE, REL_SLIDER);
        send_beam(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 3'd5, 3'd7);
        send_beam(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 3'd6, REL_HINGE);
        send_beam(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, REL_RIGID, REL_RIGID);   // zero length
        send_beam(32'd0, 32'd0, 32'd0, REL_SLIDER, REL_RIGID);
        send_beam(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, REL_RIGID, REL_RIGID);
        send_beam(32'd655, 32'hFFFF_FFFF, 32'd1, REL_HINGE, REL_RIGID);         // shortest
        send_beam(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, REL_RIGID, REL_RIGID);
        send_beam(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, REL_RIGID, REL_HINGE);
        send_beam(32'h0001_0000, 32'd0, 32'd0, REL_RIGID, REL_RIGID);           // zero loads
        settle();

        // All registers at their top, to drive the stiffness terms into saturation.
        write_all('1, '1, '1);
        send_beam(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, REL_RIGID, REL_RIGID);
        send_beam(32'd655, 32'h0001_0000, 32'h0001_0000, REL_SLIDER, REL_SLIDER);
        random_beams(20);
        settle();

        // All registers zero: only load terms survive.
        write_all('0, '0, '0);
        send_beam(32'd0, 32'h0001_0000, 32'h0001_0000, REL_RIGID, REL_RIGID);
        random_beams(20);
        settle();

        // Random settings, realistic and raw.
        for (int ph = 0; ph < 4; ph++) begin
            write_all($urandom_range(ph[0] ? 32'hFFFF_FFFF : 32'd300000000, 1),
                      $urandom(), $urandom_range(ph[1] ? 32'hFFFF_FFFF : 32'd2000000, 0));
            random_beams(40);
            settle();
        end

        // Closing phase at full rate, back at the reset-time values.
        write_all(32'd210000000, 32'd21474836, 32'd214748);
        quiet = 1'b1;
        random_beams(45);
        settle();

        $display("Covered %0d beams and %0d rows over seven register settings,",
                 board.beams_seen, board.rows_seen);
        $display("all release pairs, zero and extreme lengths, saturating loads.");
        if (board.errors == 0 && board.pending() == 0)
            $display("frame_element_stiffness_unit verification clean");
        else
            $display("frame_element_stiffness_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
